### rtl/tkip_pkg.sv
`default_nettype none

package tkip_pkg;

  // Sizes of the mixing schedule.
  localparam int unsigned Phase1Rounds = 8;
  localparam int unsigned RoundW       = $clog2(Phase1Rounds);
  localparam int unsigned Phase1Words  = 5;
  localparam int unsigned Phase2Words  = 6;
  localparam int unsigned IdxW         = 3;

  // Constants of the key packing.
  localparam logic [7:0] KeyByte1Set  = 8'h20;
  localparam logic [7:0] KeyByte1Mask = 8'h7f;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    REG_TK_LOW  = 2'd0,
    REG_TK_HIGH = 2'd1,
    REG_TA      = 2'd2,
    REG_NONE    = 2'd3
  } cfg_reg_e;

  // Input and result transactions.
  typedef struct packed {
    logic [31:0] seq_high;
    logic [15:0] seq_low;
  } in_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } out_t;

  // Function of the shared mixing unit.
  typedef enum logic [1:0] {
    MIX_SBOX,
    MIX_ROT,
    MIX_PASS
  } mix_mode_e;

  typedef struct packed {
    mix_mode_e          mode;
    logic [RoundW-1:0]  add;
  } mix_ctrl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE1,
    ST_P2_INIT,
    ST_PHASE2,
    ST_DONE
  } state_e;

  // Byte substitution table of the mixing function.
  localparam logic [15:0] SBOX_TAB [256] = '{
    16'hC6A5, 16'hF884, 16'hEE99, 16'hF68D, 16'hFF0D, 16'hD6BD, 16'hDEB1, 16'h9154,
    16'h6050, 16'h0203, 16'hCEA9, 16'h567D, 16'hE719, 16'hB562, 16'h4DE6, 16'hEC9A,
    16'h8F45, 16'h1F9D, 16'h8940, 16'hFA87, 16'hEF15, 16'hB2EB, 16'h8EC9, 16'hFB0B,
    16'h41EC, 16'hB367, 16'h5FFD, 16'h45EA, 16'h23BF, 16'h53F7, 16'hE496, 16'h9B5B,
    16'h75C2, 16'hE11C, 16'h3DAE, 16'h4C6A, 16'h6C5A, 16'h7E41, 16'hF502, 16'h834F,
    16'h685C, 16'h51F4, 16'hD134, 16'hF908, 16'hE293, 16'hAB73, 16'h6253, 16'h2A3F,
    16'h080C, 16'h9552, 16'h4665, 16'h9D5E, 16'h3028, 16'h37A1, 16'h0A0F, 16'h2FB5,
    16'h0E09, 16'h2436, 16'h1B9B, 16'hDF3D, 16'hCD26, 16'h4E69, 16'h7FCD, 16'hEA9F,
    16'h121B, 16'h1D9E, 16'h5874, 16'h342E, 16'h362D, 16'hDCB2, 16'hB4EE, 16'h5BFB,
    16'hA4F6, 16'h764D, 16'hB761, 16'h7DCE, 16'h527B, 16'hDD3E, 16'h5E71, 16'h1397,
    16'hA6F5, 16'hB968, 16'h0000, 16'hC12C, 16'h4060, 16'hE31F, 16'h79C8, 16'hB6ED,
    16'hD4BE, 16'h8D46, 16'h67D9, 16'h724B, 16'h94DE, 16'h98D4, 16'hB0E8, 16'h854A,
    16'hBB6B, 16'hC52A, 16'h4FE5, 16'hED16, 16'h86C5, 16'h9AD7, 16'h6655, 16'h1194,
    16'h8ACF, 16'hE910, 16'h0406, 16'hFE81, 16'hA0F0, 16'h7844, 16'h25BA, 16'h4BE3,
    16'hA2F3, 16'h5DFE, 16'h80C0, 16'h058A, 16'h3FAD, 16'h21BC, 16'h7048, 16'hF104,
    16'h63DF, 16'h77C1, 16'hAF75, 16'h4263, 16'h2030, 16'hE51A, 16'hFD0E, 16'hBF6D,
    16'h814C, 16'h1814, 16'h2635, 16'hC32F, 16'hBEE1, 16'h35A2, 16'h88CC, 16'h2E39,
    16'h9357, 16'h55F2, 16'hFC82, 16'h7A47, 16'hC8AC, 16'hBAE7, 16'h322B, 16'hE695,
    16'hC0A0, 16'h1998, 16'h9ED1, 16'hA37F, 16'h4466, 16'h547E, 16'h3BAB, 16'h0B83,
    16'h8CCA, 16'hC729, 16'h6BD3, 16'h283C, 16'hA779, 16'hBCE2, 16'h161D, 16'hAD76,
    16'hDB3B, 16'h6456, 16'h744E, 16'h141E, 16'h92DB, 16'h0C0A, 16'h486C, 16'hB8E4,
    16'h9F5D, 16'hBD6E, 16'h43EF, 16'hC4A6, 16'h39A8, 16'h31A4, 16'hD337, 16'hF28B,
    16'hD532, 16'h8B43, 16'h6E59, 16'hDAB7, 16'h018C, 16'hB164, 16'h9CD2, 16'h49E0,
    16'hD8B4, 16'hACFA, 16'hF307, 16'hCF25, 16'hCAAF, 16'hF48E, 16'h47E9, 16'h1018,
    16'h6FD5, 16'hF088, 16'h4A6F, 16'h5C72, 16'h3824, 16'h57F1, 16'h73C7, 16'h9751,
    16'hCB23, 16'hA17C, 16'hE89C, 16'h3E21, 16'h96DD, 16'h61DC, 16'h0D86, 16'h0F85,
    16'hE090, 16'h7C42, 16'h71C4, 16'hCCAA, 16'h90D8, 16'h0605, 16'hF701, 16'h1C12,
    16'hC2A3, 16'h6A5F, 16'hAEF9, 16'h69D0, 16'h1791, 16'h9958, 16'h3A27, 16'h27B9,
    16'hD938, 16'hEB13, 16'h2BB3, 16'h2233, 16'hD2BB, 16'hA970, 16'h0789, 16'h33A7,
    16'h2DB6, 16'h3C22, 16'h1592, 16'hC920, 16'h8749, 16'hAAFF, 16'h5078, 16'hA57A,
    16'h038F, 16'h59F8, 16'h0980, 16'h1A17, 16'h65DA, 16'hD731, 16'h84C6, 16'hD0B8,
    16'h82C3, 16'h29B0, 16'h5A77, 16'h1E11, 16'h7BCB, 16'hA8FC, 16'h6DD6, 16'h2C3A
  };

endpackage

`default_nettype wire

### rtl/tkip_mix_unit.sv
`default_nettype none

module tkip_mix_unit
  import tkip_pkg::*;
(
  input  mix_ctrl_t   ctrl_i,
  input  logic [15:0] acc_i,
  input  logic [15:0] src_i,
  input  logic [15:0] key_i,
  output logic [15:0] res_o
);

  logic [15:0] mixed;
  logic [15:0] sb_lo;
  logic [15:0] sb_hi;
  logic [15:0] func;

  // Key addition ahead of the nonlinear step.
  assign mixed = src_i ^ key_i;

  // Two table lookups, the upper one byte-swapped.
  assign sb_lo = SBOX_TAB[mixed[7:0]];
  assign sb_hi = SBOX_TAB[mixed[15:8]];

  // Select the word function for this step.
  always_comb begin
    unique case (ctrl_i.mode)
      MIX_SBOX: func = sb_lo ^ {sb_hi[7:0], sb_hi[15:8]};
      MIX_ROT:  func = {mixed[0], mixed[15:1]};
      MIX_PASS: func = mixed;
      default:  func = mixed;
    endcase
  end

  // Accumulate modulo 2^16 with the round constant.
  assign res_o = acc_i + func + {{(16-RoundW){1'b0}}, ctrl_i.add};

endmodule

`default_nettype wire

### rtl/tkip_per_packet_key_mixer.sv
// Flow: an accepted input transaction runs phase 1 (40 mixing steps) only when the
// phase-1 cache is empty or its tag differs from seq_high, then phase 2.
// Every step uses the single shared 16-bit mixing unit; a new transaction is taken
// only in ST_IDLE, once the previous result has gone into the output register.
// Reset: keys, address and phase-1 cache cleared, cache empty, output empty.
`default_nettype none

module tkip_per_packet_key_mixer
  import tkip_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  state_e state_q, state_d;

  logic [63:0] tk_low_q;
  logic [63:0] tk_high_q;
  logic [47:0] ta_q;
  logic [31:0] tag_q;
  logic        cache_valid_q;

  // Phase-1 words as a rotating line: slot 0 is the word being updated,
  // the last slot holds the word updated just before.
  logic [15:0] w_q [Phase1Words];
  logic [15:0] p_q [Phase2Words];
  logic [15:0] seq_low_q;

  logic [RoundW-1:0] round_q;
  logic [IdxW-1:0]   idx_q;
  logic              pass_q;

  logic        in_fire;
  logic        out_free;
  logic        cfg_fire;
  logic        miss;
  logic        p1_last;
  logic        p2_last;

  mix_ctrl_t   mix_ctrl;
  logic [15:0] mix_acc;
  logic [15:0] mix_src;
  logic [15:0] mix_key;
  logic [15:0] mix_res;
  logic [2:0]  key_sel;
  logic        key_en;

  logic        out_valid_q;
  out_t        out_q;
  out_t        out_d;

  // Temporal key word n, little-endian 16-bit.
  function automatic logic [15:0] key_word(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [2:0] n);
    logic [63:0] src;
    src = n[2] ? hi : lo;
    unique case (n[1:0])
      2'd0:    key_word = src[15:0];
      2'd1:    key_word = src[31:16];
      2'd2:    key_word = src[47:32];
      default: key_word = src[63:48];
    endcase
  endfunction

  // Handshakes.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign miss        = !cache_valid_q || (tag_q != in_data_i.seq_high);
  assign p1_last     = (round_q == RoundW'(Phase1Rounds - 1)) &&
                       (idx_q == IdxW'(Phase1Words - 1));
  assign p2_last     = pass_q && (idx_q == IdxW'(Phase2Words - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = miss ? ST_PHASE1 : ST_P2_INIT;
        end
      end
      ST_PHASE1: begin
        if (p1_last) begin
          state_d = ST_P2_INIT;
        end
      end
      ST_P2_INIT: state_d = ST_PHASE2;
      ST_PHASE2: begin
        if (p2_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    mix_ctrl.mode = MIX_SBOX;
    mix_ctrl.add  = '0;
    mix_acc       = p_q[0];
    mix_src       = p_q[Phase2Words-1];
    key_sel       = idx_q;
    key_en        = 1'b1;
    unique case (state_q)
      ST_PHASE1: begin
        mix_acc = w_q[0];
        mix_src = w_q[Phase1Words-1];
        key_sel = {idx_q[1:0], round_q[0]};
        if (idx_q == IdxW'(Phase1Words - 1)) begin
          mix_ctrl.add = round_q;
        end
      end
      ST_P2_INIT: begin
        mix_ctrl.mode = MIX_PASS;
        mix_acc       = w_q[Phase1Words-1];
        mix_src       = seq_low_q;
        key_en        = 1'b0;
      end
      ST_PHASE2: begin
        if (pass_q) begin
          mix_ctrl.mode = MIX_ROT;
          key_sel       = {2'b11, idx_q[0]};
          key_en        = (idx_q < IdxW'(2));
        end
      end
      default: begin
        key_en = 1'b0;
      end
    endcase
  end

  assign mix_key = key_en ? key_word(tk_low_q, tk_high_q, key_sel) : '0;

  tkip_mix_unit u_mix (
    .ctrl_i (mix_ctrl),
    .acc_i  (mix_acc),
    .src_i  (mix_src),
    .key_i  (mix_key),
    .res_o  (mix_res)
  );

  // Key packing from the finished phase-2 words.
  always_comb begin
    logic [15:0] k0mix;
    k0mix = p_q[5] ^ key_word(tk_low_q, tk_high_q, 3'd0);
    out_d.key_low  = {p_q[1], p_q[0], k0mix[8:1], seq_low_q[7:0],
                      (seq_low_q[15:8] | KeyByte1Set) & KeyByte1Mask, seq_low_q[15:8]};
    out_d.key_high = {p_q[5], p_q[4], p_q[3], p_q[2]};
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cache_valid_q <= 1'b0;
      tag_q         <= '0;
      tk_low_q      <= '0;
      tk_high_q     <= '0;
      ta_q          <= '0;
      out_valid_q   <= 1'b0;
      round_q       <= '0;
      idx_q         <= '0;
      pass_q        <= 1'b0;
    end else begin
      state_q <= state_d;

      // Configuration writes; an unlisted index leaves the cache alone.
      if (cfg_fire) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_TK_LOW:  tk_low_q  <= cfg_data_i;
          REG_TK_HIGH: tk_high_q <= cfg_data_i;
          REG_TA:      ta_q      <= cfg_data_i[47:0];
          default:     ;
        endcase
        if (cfg_reg_e'(cfg_index_i) != REG_NONE) begin
          cache_valid_q <= 1'b0;
        end
      end

      // A miss refills the cache under the new tag.
      if (in_fire && miss) begin
        tag_q         <= in_data_i.seq_high;
        cache_valid_q <= 1'b1;
      end

      // Step counters.
      unique case (state_q)
        ST_PHASE1: begin
          if (idx_q == IdxW'(Phase1Words - 1)) begin
            idx_q   <= '0;
            round_q <= round_q + 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_PHASE2: begin
          if (idx_q == IdxW'(Phase2Words - 1)) begin
            idx_q  <= '0;
            pass_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
          idx_q   <= '0;
          round_q <= '0;
          pass_q  <= 1'b0;
        end
      endcase

      // Result register.
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Word lines and captured payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Phase1Words; i++) begin
        w_q[i] <= '0;
      end
    end else begin
      if (in_fire && miss) begin
        w_q[0] <= in_data_i.seq_high[15:0];
        w_q[1] <= in_data_i.seq_high[31:16];
        w_q[2] <= ta_q[15:0];
        w_q[3] <= ta_q[31:16];
        w_q[4] <= ta_q[47:32];
      end else if (state_q == ST_PHASE1) begin
        for (int i = 0; i < Phase1Words - 1; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[Phase1Words-1] <= mix_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seq_low_q <= in_data_i.seq_low;
    end
    if (state_q == ST_P2_INIT) begin
      for (int i = 0; i < Phase1Words; i++) begin
        p_q[i] <= w_q[i];
      end
      p_q[Phase2Words-1] <= mix_res;
    end else if (state_q == ST_PHASE2) begin
      for (int i = 0; i < Phase2Words - 1; i++) begin
        p_q[i] <= p_q[i+1];
      end
      p_q[Phase2Words-1] <= mix_res;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### tb/sv/tkip_per_packet_key_mixer_tb.sv
`timescale 1ns / 1ps

module tkip_per_packet_key_mixer_tb;
  import tkip_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned PhaseFrames = 250;
  localparam int unsigned PhaseCount  = 6;

  // Predicts the per-frame key of every accepted input transaction and checks
  // the result transactions against those predictions in order.
  class key_scoreboard;
    logic [63:0] tk_lo;
    logic [63:0] tk_hi;
    logic [47:0] ta;
    logic [15:0] ttak [Phase1Words];
    logic [31:0] ttak_tag;
    bit          ttak_valid;
    out_t        expected_keys [$];
    int          mismatches;

    function new();
      tk_lo      = '0;
      tk_hi      = '0;
      ta         = '0;
      ttak_tag   = '0;
      ttak_valid = 1'b0;
      mismatches = 0;
      for (int i = 0; i < Phase1Words; i++) begin
        ttak[i] = '0;
      end
    endfunction

    // Little-endian 16-bit word n of the temporal key.
    function logic [15:0] tk_word(int unsigned n);
      logic [63:0] src;
      src = ((n & 4) != 0) ? tk_hi : tk_lo;
      return src[16 * (n % 4) +: 16];
    endfunction

    function logic [15:0] sbox_mix(logic [15:0] v);
      logic [15:0] a;
      a = SBOX_TAB[v[15:8]];
      return SBOX_TAB[v[7:0]] ^ {a[7:0], a[15:8]};
    endfunction

    function logic [15:0] rotr1(logic [15:0] v);
      return {v[0], v[15:1]};
    endfunction

    // Any write to a real register drops the cached phase-1 words.
    function void write_reg(cfg_reg_e idx, logic [63:0] val);
      case (idx)
        REG_TK_LOW:  tk_lo = val;
        REG_TK_HIGH: tk_hi = val;
        REG_TA:      ta = val[47:0];
        default:     return;
      endcase
      ttak_valid = 1'b0;
    endfunction

    function void note_frame(in_t frame);
      logic [15:0] p [Phase2Words];
      logic [15:0] lo;
      logic [15:0] tail;
      out_t        key;
      lo = frame.seq_low;

      // Phase 1 runs only on an empty cache or a new upper counter value.
      if (!ttak_valid || ttak_tag != frame.seq_high) begin
        ttak[0] = frame.seq_high[15:0];
        ttak[1] = frame.seq_high[31:16];
        ttak[2] = ta[15:0];
        ttak[3] = ta[31:16];
        ttak[4] = ta[47:32];
        for (int r = 0; r < Phase1Rounds; r++) begin
          ttak[0] = ttak[0] + sbox_mix(ttak[4] ^ tk_word(r % 2));
          ttak[1] = ttak[1] + sbox_mix(ttak[0] ^ tk_word(2 + r % 2));
          ttak[2] = ttak[2] + sbox_mix(ttak[1] ^ tk_word(4 + r % 2));
          ttak[3] = ttak[3] + sbox_mix(ttak[2] ^ tk_word(6 + r % 2));
          ttak[4] = ttak[4] + sbox_mix(ttak[3] ^ tk_word(r % 2)) + 16'(r);
        end
        ttak_tag   = frame.seq_high;
        ttak_valid = 1'b1;
      end

      // Phase 2 mixes in the low counter bits.
      for (int i = 0; i < Phase1Words; i++) begin
        p[i] = ttak[i];
      end
      p[5] = ttak[4] + lo;
      p[0] = p[0] + sbox_mix(p[5] ^ tk_word(0));
      p[1] = p[1] + sbox_mix(p[0] ^ tk_word(1));
      p[2] = p[2] + sbox_mix(p[1] ^ tk_word(2));
      p[3] = p[3] + sbox_mix(p[2] ^ tk_word(3));
      p[4] = p[4] + sbox_mix(p[3] ^ tk_word(4));
      p[5] = p[5] + sbox_mix(p[4] ^ tk_word(5));
      p[0] = p[0] + rotr1(p[5] ^ tk_word(6));
      p[1] = p[1] + rotr1(p[0] ^ tk_word(7));
      p[2] = p[2] + rotr1(p[1]);
      p[3] = p[3] + rotr1(p[2]);
      p[4] = p[4] + rotr1(p[3]);
      p[5] = p[5] + rotr1(p[4]);

      // Pack the sixteen key bytes.
      tail = p[5] ^ tk_word(0);
      key.key_low  = {p[1], p[0], tail[8:1], lo[7:0],
                      (lo[15:8] | KeyByte1Set) & KeyByte1Mask, lo[15:8]};
      key.key_high = {p[5], p[4], p[3], p[2]};
      expected_keys.push_back(key);
    endfunction

    function void check_key(out_t got);
      out_t want;
      if (expected_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected key: key_high %h key_low %h", got.key_high, got.key_low);
        end
        return;
      end
      want = expected_keys.pop_front();
      if (got.key_low !== want.key_low || got.key_high !== want.key_high) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("key mismatch: key_low exp %h got %h, key_high exp %h got %h",
                   want.key_low, got.key_low, want.key_high, got.key_high);
        end
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_ready_o;
  in_t          in_data_i;
  logic         out_valid_o;
  logic         out_ready_i;
  out_t         out_data_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0]  cfg_data_i;

  key_scoreboard sb;
  int unsigned   burst_left;
  int unsigned   cycle_count;

  tkip_per_packet_key_mixer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every accepted result transaction is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_key(out_data_o);
    end
  end

  // The receiver stalls on a rotating 16-bit pattern that is reloaded for each
  // window; some windows are fully ready, some mostly stalled.
  initial begin
    logic [15:0] stall_pattern;
    int unsigned mode;
    out_ready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      stall_pattern = 16'($urandom);
      if (mode == 3) begin
        stall_pattern = stall_pattern & 16'($urandom);
      end
      repeat (64) begin
        @(negedge clk_i);
        out_ready_i <= (mode == 0) ? 1'b1 : stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // Sends one frame counter; the sender works in bursts with random gaps.
  task automatic send_frame(in_t frame);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= frame;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_frame(frame);
  endtask

  // Stops the sender and waits for every outstanding key.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.expected_keys.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_reg(cfg_reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly consecutive frame counters, with jumps and counters close to the
  // point where the low half wraps into the upper half.
  task automatic run_random_frames(int unsigned count);
    logic [47:0] ctr;
    int unsigned pick;
    ctr = {16'($urandom), $urandom};
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        ctr = ctr + 48'd1;
      end else if (pick < 8) begin
        ctr[15:0] = 16'($urandom);
      end else if (pick == 8) begin
        ctr = {16'($urandom), $urandom};
      end else begin
        ctr = {$urandom, 16'($urandom_range(16'hFFF8, 16'hFFFF))};
      end
      send_frame(in_t'{ctr[47:16], ctr[15:0]});
    end
  endtask

  initial begin
    sb          = new();
    burst_left  = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_TK_LOW;
    cfg_data_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration; the first frame hits an empty cache whose tag
    // already equals the upper counter bits.
    send_frame(in_t'{32'h0000_0000, 16'h0000});
    send_frame(in_t'{32'h0000_0000, 16'h0000});
    send_frame(in_t'{32'h0000_0000, 16'hFFFF});
    send_frame(in_t'{32'hFFFF_FFFF, 16'hFFFF});
    send_frame(in_t'{32'hFFFF_FFFF, 16'h0000});
    send_frame(in_t'{32'h0000_0000, 16'h00FF});

    // A write beyond the register list leaves the cache alone.
    settle();
    program_reg(REG_NONE, '1);
    send_frame(in_t'{32'h0000_0000, 16'hFF00});

    // All-ones configuration; the same upper bits must still be remixed.
    settle();
    program_reg(REG_TK_LOW, '1);
    program_reg(REG_TK_HIGH, '1);
    program_reg(REG_TA, '1);
    send_frame(in_t'{32'h0000_0000, 16'hFF00});
    send_frame(in_t'{32'hFFFF_FFFF, 16'hFFFF});
    send_frame(in_t'{32'h8000_0000, 16'h8000});
    send_frame(in_t'{32'h7FFF_FFFF, 16'h7FFF});
    send_frame(in_t'{32'hAAAA_AAAA, 16'h5555});

    // Single register writes, each followed by a frame with the cached tag.
    settle();
    program_reg(REG_TK_LOW, 64'h0123_4567_89AB_CDEF);
    send_frame(in_t'{32'hAAAA_AAAA, 16'h5555});
    settle();
    program_reg(REG_TA, 64'hFFFF_0000_5A5A_A5A5);
    send_frame(in_t'{32'hAAAA_AAAA, 16'hAAAA});
    settle();
    program_reg(REG_TK_HIGH, 64'h0);
    send_frame(in_t'{32'hAAAA_AAAA, 16'h0100});
    send_frame(in_t'{32'h5555_5555, 16'hFFFF});
    send_frame(in_t'{32'h5555_5556, 16'h0000});

    // Random phases, the first with an all-zero and the last with an
    // all-ones configuration.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      settle();
      if (phase == 0) begin
        program_reg(REG_TK_LOW, '0);
        program_reg(REG_TK_HIGH, '0);
        program_reg(REG_TA, '0);
      end else if (phase == PhaseCount - 1) begin
        program_reg(REG_TA, '1);
        program_reg(REG_TK_HIGH, '1);
        program_reg(REG_TK_LOW, '1);
      end else begin
        program_reg(REG_TK_HIGH, {$urandom, $urandom});
        program_reg(REG_NONE, {$urandom, $urandom});
        program_reg(REG_TA, {$urandom, $urandom});
        program_reg(REG_TK_LOW, {$urandom, $urandom});
      end
      run_random_frames(PhaseFrames);
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_keys.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
